/* hw/rtl/lr_pkg.sv */
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, codes and record types of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 24;
  localparam int DEPTH_BITS = 16;
  localparam int CFG_BITS   = 1;

  localparam logic [COLOR_BITS-1:0] COLOR_RAISED_RESET = 24'h0000ff;
  localparam logic [COLOR_BITS-1:0] COLOR_FLAT_RESET   = 24'hffffff;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef enum logic [CFG_BITS-1:0] {
    REG_COLOR_RAISED = 1'b0,
    REG_COLOR_FLAT   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  typedef struct packed {
    logic   first_valid;
    logic   second_valid;
    pixel_t first;
    pixel_t second;
  } push_t;

endpackage

/* hw/rtl/lr_core.sv */
// ----------------------------------------------------------------------------
// Line rasterizer core
// Line state and combinational start / step update; emits up to two pixels.
// ----------------------------------------------------------------------------
module lr_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic                                 func,
  input  logic signed [lr_pkg::COORD_BITS-1:0] x_start,
  input  logic signed [lr_pkg::COORD_BITS-1:0] y_start,
  input  logic signed [lr_pkg::COORD_BITS-1:0] x_end,
  input  logic signed [lr_pkg::COORD_BITS-1:0] y_end,
  input  logic signed [lr_pkg::DEPTH_BITS-1:0] depth,
  input  logic        [lr_pkg::COLOR_BITS-1:0] color_raised,
  input  logic        [lr_pkg::COLOR_BITS-1:0] color_flat,
  output lr_pkg::push_t                        push
);

  logic [lr_pkg::COORD_BITS-1:0] cur_x, cur_x_next;
  logic [lr_pkg::COORD_BITS-1:0] cur_y, cur_y_next;
  logic [lr_pkg::ERR_BITS-1:0]   err_acc, err_acc_next;
  logic [lr_pkg::DELTA_BITS-1:0] delta_x, delta_x_next;
  logic [lr_pkg::DELTA_BITS-1:0] delta_y, delta_y_next;
  logic [lr_pkg::DELTA_BITS-1:0] steps_left, steps_left_next;
  logic x_goes_down, x_goes_down_next;
  logic y_goes_down, y_goes_down_next;
  logic major_is_x, major_is_x_next;
  logic raised_flag, raised_flag_next;

  logic signed [lr_pkg::DELTA_BITS-1:0] xs_w, ys_w, xe_w, ye_w;
  logic [lr_pkg::DELTA_BITS-1:0] s_dx, s_dy, s_major;
  logic s_xdown, s_ydown, s_major_x, s_raised;
  logic [lr_pkg::COLOR_BITS-1:0] s_color, t_color;

  logic [lr_pkg::DELTA_BITS-1:0] t_major, t_minor, t_steps;
  logic [lr_pkg::ERR_BITS-1:0]   t_sum, t_err;
  logic                          t_bump, t_active;
  logic [lr_pkg::COORD_BITS-1:0] t_xstep, t_ystep, t_x, t_y;

  // start item
  always_comb begin
    xs_w      = {x_start[lr_pkg::COORD_BITS-1], x_start};
    ys_w      = {y_start[lr_pkg::COORD_BITS-1], y_start};
    xe_w      = {x_end[lr_pkg::COORD_BITS-1], x_end};
    ye_w      = {y_end[lr_pkg::COORD_BITS-1], y_end};
    s_xdown   = x_start > x_end;
    s_ydown   = y_start > y_end;
    s_dx      = s_xdown ? xs_w - xe_w : xe_w - xs_w;
    s_dy      = s_ydown ? ys_w - ye_w : ye_w - ys_w;
    s_major_x = s_dx > s_dy;
    s_major   = s_major_x ? s_dx : s_dy;
    s_raised  = depth > 0;
    s_color   = s_raised ? color_raised : color_flat;
  end

  // step item
  always_comb begin
    t_active = steps_left != '0;
    t_major  = major_is_x ? delta_x : delta_y;
    t_minor  = major_is_x ? delta_y : delta_x;
    t_sum    = err_acc + {1'b0, t_minor};
    t_bump   = t_sum > {1'b0, t_major};
    t_err    = t_bump ? t_sum - {1'b0, t_major} : t_sum;
    t_xstep  = x_goes_down ? '1 : lr_pkg::COORD_BITS'(1);
    t_ystep  = y_goes_down ? '1 : lr_pkg::COORD_BITS'(1);
    t_x      = (major_is_x || t_bump) ? cur_x + t_xstep : cur_x;
    t_y      = (!major_is_x || t_bump) ? cur_y + t_ystep : cur_y;
    t_steps  = steps_left - lr_pkg::DELTA_BITS'(1);
    t_color  = raised_flag ? color_raised : color_flat;
  end

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    err_acc_next     = err_acc;
    delta_x_next     = delta_x;
    delta_y_next     = delta_y;
    steps_left_next  = steps_left;
    x_goes_down_next = x_goes_down;
    y_goes_down_next = y_goes_down;
    major_is_x_next  = major_is_x;
    raised_flag_next = raised_flag;

    push.first_valid   = 1'b0;
    push.second_valid  = 1'b0;
    push.first.x       = x_start;
    push.first.y       = y_start;
    push.first.color   = s_color;
    push.first.last    = 1'b0;
    push.second.x      = x_end;
    push.second.y      = y_end;
    push.second.color  = s_color;
    push.second.last   = s_major == '0;

    if (accept) begin
      case (lr_pkg::func_t'(func))
        lr_pkg::FUNC_START: begin
          cur_x_next        = x_start;
          cur_y_next        = y_start;
          err_acc_next      = lr_pkg::ERR_BITS'(s_major[lr_pkg::DELTA_BITS-1:1]);
          delta_x_next      = s_dx;
          delta_y_next      = s_dy;
          steps_left_next   = s_major;
          x_goes_down_next  = s_xdown;
          y_goes_down_next  = s_ydown;
          major_is_x_next   = s_major_x;
          raised_flag_next  = s_raised;
          push.first_valid  = 1'b1;
          push.second_valid = 1'b1;
        end
        lr_pkg::FUNC_STEP: begin
          if (t_active) begin
            cur_x_next       = t_x;
            cur_y_next       = t_y;
            err_acc_next     = t_err;
            steps_left_next  = t_steps;
            push.first_valid = 1'b1;
            push.first.x     = t_x;
            push.first.y     = t_y;
            push.first.color = t_color;
            push.first.last  = t_steps == '0;
          end
        end
        default: begin
          push.first_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      err_acc     <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      steps_left  <= '0;
      x_goes_down <= 1'b0;
      y_goes_down <= 1'b0;
      major_is_x  <= 1'b0;
      raised_flag <= 1'b0;
    end else begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      err_acc     <= err_acc_next;
      delta_x     <= delta_x_next;
      delta_y     <= delta_y_next;
      steps_left  <= steps_left_next;
      x_goes_down <= x_goes_down_next;
      y_goes_down <= y_goes_down_next;
      major_is_x  <= major_is_x_next;
      raised_flag <= raised_flag_next;
    end
  end

endmodule

/* hw/rtl/lr_outq.sv */
// ----------------------------------------------------------------------------
// Line rasterizer output queue
// Small pixel queue taking up to two beats per cycle, giving one per cycle while pixel_ready is high.
// ----------------------------------------------------------------------------
module lr_outq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lr_pkg::push_t                        push,
  output logic                                 room,
  output logic                                 pixel_valid,
  input  logic                                 pixel_ready,
  output logic signed [lr_pkg::COORD_BITS-1:0] pixel_x,
  output logic signed [lr_pkg::COORD_BITS-1:0] pixel_y,
  output logic        [lr_pkg::COLOR_BITS-1:0] color,
  output logic                                 last
);

  lr_pkg::pixel_t mem [lr_pkg::FIFO_DEPTH];
  logic [lr_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [lr_pkg::FIFO_CW-1:0] count, count_next;
  logic [lr_pkg::FIFO_CW-1:0] n_push;
  logic                       pop;
  lr_pkg::pixel_t             head;

  always_comb begin
    n_push      = lr_pkg::FIFO_CW'(push.first_valid) + lr_pkg::FIFO_CW'(push.second_valid);
    pixel_valid = count != '0;
    pop         = pixel_valid && pixel_ready;
    count_next  = count + n_push - lr_pkg::FIFO_CW'(pop);
    room        = count <= lr_pkg::FIFO_CW'(lr_pkg::FIFO_DEPTH - 2);
    head        = mem[rd_ptr];
    pixel_x     = head.x;
    pixel_y     = head.y;
    color       = head.color;
    last        = head.last;
  end

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[wr_ptr + lr_pkg::FIFO_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[lr_pkg::FIFO_AW-1:0];
      rd_ptr <= rd_ptr + lr_pkg::FIFO_AW'(pop);
      count  <= count_next;
    end
  end

endmodule

/* hw/rtl/line_rasterizer.sv */
// ----------------------------------------------------------------------------
// Line rasterizer
// Bresenham line stepping with two colour registers and a pixel queue.
// ----------------------------------------------------------------------------
//   channel   signals                          beat
//   item      item_valid / item_ready          func, endpoints, depth
//   pixel     pixel_valid / pixel_ready        pixel_x, pixel_y, color, last
//   cfg       cfg_valid / cfg_ready            cfg_index, cfg_data
//
// One item per cycle while item_ready is high: the line state updates in
// the cycle of the beat and its pixels enter a four-entry queue. A start
// item leaves two pixel beats, so back-to-back starts are bounded by the
// pixel port. item_ready drops while the queue has fewer than two free
// entries. Reset clears the line state and the queue and restores the
// reset colours.
// ----------------------------------------------------------------------------
module line_rasterizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic                                 func,
  input  logic signed [lr_pkg::COORD_BITS-1:0] x_start,
  input  logic signed [lr_pkg::COORD_BITS-1:0] y_start,
  input  logic signed [lr_pkg::COORD_BITS-1:0] x_end,
  input  logic signed [lr_pkg::COORD_BITS-1:0] y_end,
  input  logic signed [lr_pkg::DEPTH_BITS-1:0] depth,
  output logic                                 pixel_valid,
  input  logic                                 pixel_ready,
  output logic signed [lr_pkg::COORD_BITS-1:0] pixel_x,
  output logic signed [lr_pkg::COORD_BITS-1:0] pixel_y,
  output logic        [lr_pkg::COLOR_BITS-1:0] color,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [lr_pkg::CFG_BITS-1:0]   cfg_index,
  input  logic        [lr_pkg::COLOR_BITS-1:0] cfg_data
);

  logic [lr_pkg::COLOR_BITS-1:0] color_raised;
  logic [lr_pkg::COLOR_BITS-1:0] color_flat;
  logic                          room;
  logic                          accept;
  lr_pkg::push_t                 push;

  assign cfg_ready  = 1'b1;
  assign item_ready = room;
  assign accept     = item_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_raised <= lr_pkg::COLOR_RAISED_RESET;
      color_flat   <= lr_pkg::COLOR_FLAT_RESET;
    end else if (cfg_valid) begin
      case (lr_pkg::cfg_reg_t'(cfg_index))
        lr_pkg::REG_COLOR_RAISED: color_raised <= cfg_data;
        lr_pkg::REG_COLOR_FLAT:   color_flat   <= cfg_data;
        default: begin
          color_raised <= color_raised;
        end
      endcase
    end
  end

  lr_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (func),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .depth        (depth),
    .color_raised (color_raised),
    .color_flat   (color_flat),
    .push         (push)
  );

  lr_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .color       (color),
    .last        (last)
  );

endmodule
